// File: rtl/core/tts_pkg.sv
// Shared types and constants for the tick timer slot bank.
`default_nettype none

package tts_pkg;

   // Default sizing of the bank
   localparam int TIMER_SLOTS_DEFAULT = 16;
   localparam int TICK_WIDTH_DEFAULT  = 32;

   // Depth of the command queue between front and back
   localparam int CMD_FIFO_DEPTH = 2;

   // Request mode codes as they arrive on the port
   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;

   // Request item
   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  slot;
      logic [31:0] interval;
      logic        one_shot;
   } req_type;

   // Result item
   typedef struct packed {
      logic [3:0] expired_slot;
      logic       was_one_shot;
      logic       last;
   } rsp_type;

   // Classified command kinds held in the queue
   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_kind_type;

   // Command handed from front to back
   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   slot;
      logic [31:0]  interval;
      logic         one_shot;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/tts_front.sv
// Front end: accepts request items, drops meaningless ones, queues commands.
`default_nettype none

module tts_front
   import tts_pkg::*;
#(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         cmd_valid,
   output cmd_type      cmd_data,
   input  wire logic    cmd_pop
);

   localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type               queue_ff [CMD_FIFO_DEPTH];
   logic    [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic    [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic    [CNT_W-1:0]   count_ff, count_in;
   logic                  accept;
   logic                  keep;
   logic                  push;
   logic                  slot_ok;
   cmd_type               cmd_new;

   // Classify the incoming item
   always_comb begin
      slot_ok = 32'(req_data.slot) < TIMER_SLOTS;
      cmd_new.slot     = req_data.slot;
      cmd_new.interval = req_data.interval;
      cmd_new.one_shot = req_data.one_shot;
      cmd_new.kind     = CMD_TICK;
      keep             = 1'b0;
      case (req_data.mode)
         MODE_TICK: begin
            keep = 1'b1;
         end
         MODE_ADD: begin
            cmd_new.kind = CMD_ADD;
            keep         = slot_ok;
         end
         MODE_REMOVE: begin
            cmd_new.kind = CMD_REMOVE;
            keep         = slot_ok;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == CNT_W'(CMD_FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && keep;

   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // Queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == CMD_FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == CMD_FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

`ifndef NO_ASSERTIONS
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> count_ff != '0)
      else $error("command popped from empty queue");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CMD_FIFO_DEPTH))
      else $error("command queue overfilled");

   a_drop_no_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && !keep && !cmd_pop) |=> count_ff == $past(count_ff))
      else $error("dropped item entered the queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tts_back.sv
// Back end: slot state, add and remove, and the per-tick slot walk.
`default_nettype none

module tts_back
   import tts_pkg::*;
#(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEFAULT,
   parameter int TICK_WIDTH  = TICK_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_data,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int SLOT_IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_WALK  = 3'b010,
      S_FLUSH = 3'b100
   } back_state_type;

   back_state_type             state_ff, state_in;
   logic [TIMER_SLOTS-1:0]     active_ff, active_in;
   logic [TIMER_SLOTS-1:0]     single_ff, single_in;
   logic [SLOT_IW-1:0]         walk_ff, walk_in;
   logic                       issue_ff, issue_in;
   logic                       b_vld_ff, b_vld_in;
   logic [SLOT_IW-1:0]         b_slot_ff, b_slot_in;
   logic                       hold_vld_ff, hold_vld_in;
   logic [SLOT_IW-1:0]         hold_slot_ff, hold_slot_in;
   logic                       hold_once_ff, hold_once_in;
   logic                       out_vld_ff, out_vld_in;
   rsp_type                    out_ff, out_in;
   logic [TICK_WIDTH-1:0]      rd_rem_ff;
   logic [TICK_WIDTH-1:0]      rd_per_ff;

   logic [TICK_WIDTH-1:0]      per_mem [TIMER_SLOTS];
   logic [TICK_WIDTH-1:0]      rem_mem [TIMER_SLOTS];

   logic                       rd_en;
   logic                       per_we;
   logic                       rem_we;
   logic [SLOT_IW-1:0]         wr_addr;
   logic [TICK_WIDTH-1:0]      rem_wd;
   logic [TICK_WIDTH-1:0]      load_val;
   logic [SLOT_IW-1:0]         cmd_idx;
   logic [TICK_WIDTH-1:0]      dec;
   logic                       b_active;
   logic                       b_single;
   logic                       b_expire;
   logic                       out_free;
   logic                       advance;
   logic                       push_mid;
   logic                       push_end;

   assign cmd_idx  = SLOT_IW'(cmd_data.slot);
   assign load_val = TICK_WIDTH'(cmd_data.interval);

   // Stage B: count down the slot held in the registered read
   assign b_active = active_ff[b_slot_ff];
   assign b_single = single_ff[b_slot_ff];
   assign dec      = rd_rem_ff - 1'b1;
   assign b_expire = b_vld_ff && b_active && (dec == '0);

   // An expiry with a held result needs room in the output register
   assign out_free = !out_vld_ff || !rsp_stall;
   assign advance  = !(b_expire && hold_vld_ff && !out_free);
   assign push_mid = (state_ff == S_WALK) && b_expire && hold_vld_ff && out_free;
   assign push_end = (state_ff == S_FLUSH) && hold_vld_ff && out_free;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      single_in    = single_ff;
      walk_in      = walk_ff;
      issue_in     = issue_ff;
      b_vld_in     = b_vld_ff;
      b_slot_in    = b_slot_ff;
      hold_vld_in  = hold_vld_ff;
      hold_slot_in = hold_slot_ff;
      hold_once_in = hold_once_ff;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      per_we       = 1'b0;
      rem_we       = 1'b0;
      wr_addr      = b_slot_ff;
      rem_wd       = dec;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd_data.kind)
                  CMD_TICK: begin
                     state_in = S_WALK;
                     walk_in  = '0;
                     issue_in = 1'b1;
                     b_vld_in = 1'b0;
                  end
                  CMD_ADD: begin
                     per_we             = 1'b1;
                     rem_we             = 1'b1;
                     wr_addr            = cmd_idx;
                     rem_wd             = load_val;
                     active_in[cmd_idx] = 1'b1;
                     single_in[cmd_idx] = cmd_data.one_shot;
                  end
                  CMD_REMOVE: begin
                     active_in[cmd_idx] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_WALK: begin
            if (advance) begin
               // Write back the slot in stage B
               if (b_vld_ff && b_active) begin
                  rem_we = 1'b1;
                  rem_wd = b_expire ? rd_per_ff : dec;
                  if (b_expire) begin
                     if (b_single) begin
                        active_in[b_slot_ff] = 1'b0;
                     end
                     hold_vld_in  = 1'b1;
                     hold_slot_in = b_slot_ff;
                     hold_once_in = b_single;
                  end
               end
               // Issue the next slot read
               if (issue_ff) begin
                  rd_en     = 1'b1;
                  b_vld_in  = 1'b1;
                  b_slot_in = walk_ff;
                  walk_in   = walk_ff + 1'b1;
                  if (walk_ff == SLOT_IW'(TIMER_SLOTS - 1)) begin
                     issue_in = 1'b0;
                  end
               end else begin
                  b_vld_in = 1'b0;
                  state_in = S_FLUSH;
               end
            end
         end

         S_FLUSH: begin
            if (!hold_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               hold_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      out_vld_in = out_vld_ff && rsp_stall;
      out_in     = out_ff;
      if (push_mid || push_end) begin
         out_vld_in          = 1'b1;
         out_in.expired_slot = 4'(hold_slot_ff);
         out_in.was_one_shot = hold_once_ff;
         out_in.last         = push_end;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         active_ff   <= '0;
         single_ff   <= '0;
         walk_ff     <= '0;
         issue_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         single_ff   <= single_in;
         walk_ff     <= walk_in;
         issue_ff    <= issue_in;
         b_vld_ff    <= b_vld_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      b_slot_ff    <= b_slot_in;
      hold_slot_ff <= hold_slot_in;
      hold_once_ff <= hold_once_in;
      out_ff       <= out_in;
   end

   // Period and countdown memories, one write and one registered read
   always_ff @(posedge clock) begin
      if (per_we) begin
         per_mem[wr_addr] <= load_val;
      end
      if (rem_we) begin
         rem_mem[wr_addr] <= rem_wd;
      end
      if (rd_en) begin
         rd_per_ff <= per_mem[walk_ff];
         rd_rem_ff <= rem_mem[walk_ff];
      end
   end

`ifndef NO_ASSERTIONS
   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> state_ff != S_IDLE)
      else $error("held expiry left behind in idle");

   a_stage_walk: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> state_ff == S_WALK)
      else $error("stage B active outside a walk");

   a_mid_not_done: assert property (@(posedge clock) disable iff (reset)
      push_mid |=> (state_ff != S_IDLE && hold_vld_ff))
      else $error("non-final expiry without a following one");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      push_end |=> (out_vld_ff && out_ff.last && state_ff == S_IDLE))
      else $error("final expiry not flagged");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tick_timer_slot_bank.sv
// Top level: bank of one-shot and periodic timer slots stepped by tick items.
// Accepted items are registered in the command queue before the back end sees them; the back end
// applies an add or remove as it pops it. A tick holds the back end while it is popped, each slot
// is read in turn, each registered read is counted down and the final result is flushed.
// An expiry waits until the next expiring slot or the flush; a stalled result port holds the walk.
// Synchronous reset clears all slot flags and the queue; interval storage needs no clearing.
`default_nettype none

module tick_timer_slot_bank
   import tts_pkg::*;
#(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEFAULT,
   parameter int TICK_WIDTH  = TICK_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   // Accept and classify
   tts_front #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   // Execute commands against the slot bank
   tts_back #(
      .TIMER_SLOTS (TIMER_SLOTS),
      .TICK_WIDTH  (TICK_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
